/* rtl/pewa_pkg.sv */
// pewa_pkg: shared widths, reset values and register map of the power energy
// window averager
// no dependencies
package pewa_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    localparam int WATTS_W   = 24;
    localparam int QUAL_W    = 8;
    localparam int TS_W      = 32;
    localparam int ENERGY_W  = 48;
    localparam int WIN_W     = 16;
    localparam int GAP_W     = 8;
    localparam int CNT_OUT_W = 7;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 112;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(60);
    localparam logic [GAP_W-1:0] MAX_GAP_RST = GAP_W'(10);

    // register index as seen on paddr[2]
    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_MAX_GAP = 1'b1;

endpackage

/* rtl/pewa_ring.sv */
// pewa_ring: ring storage of timestamped power samples
// one write port, one registered read port; uses pewa_pkg
module pewa_ring #(
    parameter int DEPTH = pewa_pkg::WINDOW_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pewa_pkg::WATTS_W-1:0] i_wpower,
    input  logic [pewa_pkg::TS_W-1:0]    i_wtime,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [pewa_pkg::WATTS_W-1:0] o_rpower,
    output logic [pewa_pkg::TS_W-1:0]    o_rtime
);
    import pewa_pkg::*;

    logic [WATTS_W-1:0] r_power_mem [DEPTH];
    logic [TS_W-1:0]    r_time_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_power_mem[i_waddr] <= i_wpower;
            r_time_mem[i_waddr]  <= i_wtime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rpower <= r_power_mem[i_raddr];
            o_rtime  <= r_time_mem[i_raddr];
        end
    end

endmodule

/* rtl/pewa_divider.sv */
// pewa_divider: restoring unsigned divider, one quotient bit per cycle
// no package dependencies
module pewa_divider #(
    parameter int DVD_W = 31,
    parameter int DSR_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DSR_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W-1:0]  r_dsr;

    logic [DSR_W:0]    w_rem_sh;
    logic [DSR_W:0]    w_diff;
    logic              w_bit;

    assign w_rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dsr};
    assign w_bit    = ~w_diff[DSR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[DSR_W-1:0] : w_rem_sh[DSR_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/power_energy_window_averager.sv */
// power_energy_window_averager: top level, sequencer, energy integration and
// newest-first window walk; uses pewa_pkg, pewa_ring, pewa_divider
//
// Takes one power sample at a time and returns one result per sample: the
// sample's power and quality code, the accumulated energy in milliwatt-seconds
// (saturating at 2^48-1) and the truncated mean of ring samples within
// window_len seconds of the newest timestamp. Energy adds power * gap only when
// the previous timestamp is non-zero, the new one is later, and the gap is at
// most max_gap_seconds; clear_energy zeroes the total first. The block works on
// one sample at a time and s_axis_tready is low while it does. The walk reads
// between 1 and WINDOW_DEPTH ring entries, newest first, one per cycle from the
// single memory read port, and the mean comes from a serial divider producing
// one quotient bit per cycle. The next sample is taken while a result waits in
// the output register. Registers: window_len at byte address 0,
// max_gap_seconds at 4.
module power_energy_window_averager #(
    parameter int WINDOW_DEPTH = pewa_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [23:0] watts_mw, [31:24] quality_code, [63:32] timestamp_s
    input  logic [pewa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] clear_energy
    input  logic                              s_axis_tuser,
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [23:0] current_watts_mw, [31:24] current_quality, [79:32] energy_mws,
    // [103:80] avg_watts_mw, [110:104] samples_in_window, [111] zero
    output logic [pewa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pewa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pewa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pewa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pewa_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = WATTS_W + CNT_W;
    localparam int PROD_W = WATTS_W + GAP_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GAP  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_WALK = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [WIN_W-1:0] r_window;
    logic [GAP_W-1:0] r_max_gap;
    logic             w_cfg_wr;

    // latched sample
    logic [WATTS_W-1:0] r_watts;
    logic [QUAL_W-1:0]  r_qual;
    logic [TS_W-1:0]    r_ts;
    logic               r_clear;

    // energy path
    logic [TS_W-1:0]     r_last;
    logic [ENERGY_W-1:0] r_energy;
    logic [GAP_W-1:0]    r_gap;
    logic                r_add_en;
    logic [PROD_W-1:0]   r_prod;
    logic [TS_W-1:0]     w_gap;
    logic                w_add_en;
    logic [ENERGY_W:0]   w_energy_sum;

    // ring bookkeeping
    logic [AW-1:0]    r_head;
    logic [CNT_W-1:0] r_fill;

    // window walk
    logic [AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_issued;
    logic             r_pend;
    logic [TS_W-1:0]  r_cutoff;
    logic             r_cut_neg;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [TS_W:0]    w_cutoff;
    logic             w_stop;
    logic             w_take;
    logic             w_issue;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;

    logic [WATTS_W-1:0] w_rd_power;
    logic [TS_W-1:0]    w_rd_time;

    // divider
    logic             w_div_start;
    logic             w_div_done;
    logic [SUM_W-1:0] w_quotient;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_out_load;
    logic [WATTS_W-1:0]    w_avg;

    // ---------------------------------------------------------------
    // configuration port, no wait states
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RST;
            r_max_gap <= MAX_GAP_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_WINDOW) begin
                r_window <= pwdata[WIN_W-1:0];
            end else begin
                r_max_gap <= pwdata[GAP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MAX_GAP) ? APB_DATA_W'(r_max_gap)
                                              : APB_DATA_W'(r_window);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_GAP;
            S_GAP:  n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = S_WALK;
            S_WALK: if (!w_issue) n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_DONE;
            S_DONE: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample capture on the input transaction
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_watts <= s_axis_tdata[23:0];
            r_qual  <= s_axis_tdata[31:24];
            r_ts    <= s_axis_tdata[63:32];
            r_clear <= s_axis_tuser;
        end
    end

    // ---------------------------------------------------------------
    // energy: gap qualify, multiply, saturating accumulate
    // ---------------------------------------------------------------
    assign w_gap    = r_ts - r_last;
    assign w_add_en = (r_last != '0) && (r_ts > r_last) &&
                      (w_gap <= TS_W'(r_max_gap));
    assign w_energy_sum = {1'b0, r_energy} + (ENERGY_W + 1)'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_energy <= '0;
        end else begin
            if (r_state == S_GAP) begin
                r_last <= r_ts;
                if (r_clear) begin
                    r_energy <= '0;
                end
            end
            if (r_state == S_ACC && r_add_en) begin
                // carry out of the 48-bit sum means saturate
                r_energy <= w_energy_sum[ENERGY_W] ? ENERGY_MAX
                                                   : w_energy_sum[ENERGY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GAP) begin
            r_gap    <= w_gap[GAP_W-1:0];
            r_add_en <= w_add_en;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_watts * r_gap;
        end
    end

    // ---------------------------------------------------------------
    // ring write and fill tracking
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (r_state == S_GAP) begin
            r_head <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
            if (r_fill != CNT_W'(WINDOW_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // window walk, newest first; one read issued per cycle, data checked
    // the cycle after
    // ---------------------------------------------------------------
    assign w_cutoff = {1'b0, r_ts} - (TS_W + 1)'(r_window);

    // negative cutoff lets every stored entry qualify
    assign w_stop  = r_pend && !r_cut_neg && (w_rd_time < r_cutoff);
    assign w_take  = r_pend && !w_stop;
    assign w_issue = (r_state == S_WALK) && !w_stop && (r_issued != r_fill);

    assign n_sum = w_take ? r_sum + SUM_W'(w_rd_power) : r_sum;
    assign n_cnt = w_take ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GAP) begin
            r_rd_ptr  <= r_head;
            r_issued  <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_cutoff  <= w_cutoff[TS_W-1:0];
            r_cut_neg <= w_cutoff[TS_W];
        end else if (r_state == S_WALK) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
            if (w_issue) begin
                r_rd_ptr <= (r_rd_ptr == '0) ? AW'(WINDOW_DEPTH - 1) : r_rd_ptr - 1'b1;
                r_issued <= r_issued + 1'b1;
            end
        end
    end

    pewa_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk    (i_clk),
        .i_we     (r_state == S_GAP),
        .i_waddr  (r_head),
        .i_wpower (r_watts),
        .i_wtime  (r_ts),
        .i_re     (w_issue),
        .i_raddr  (r_rd_ptr),
        .o_rpower (w_rd_power),
        .o_rtime  (w_rd_time)
    );

    // ---------------------------------------------------------------
    // mean: serial divide started on the last walk cycle
    // ---------------------------------------------------------------
    assign w_div_start = (r_state == S_WALK) && !w_issue;

    pewa_divider #(
        .DVD_W (SUM_W),
        .DSR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_avg = (r_cnt != '0) ? w_quotient[WATTS_W-1:0] : '0;

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {1'b0, CNT_OUT_W'(r_cnt), w_avg, r_energy, r_qual, r_watts};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* rtl/pewa_checker.sv */
// pewa_checker: port-level assertions for power_energy_window_averager
// uses pewa_pkg; bound to the top level at the end of this file
module pewa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pewa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pewa_pkg::*;

    // a result waiting for the sink holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // an accepted sample keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an input transaction");

    // a new result is only produced at the end of a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a busy period");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind power_energy_window_averager pewa_checker u_pewa_checker (.*);
